[design/tsl_pkg.sv]
package tsl_pkg;

    localparam int MAX_LEVELS_DEF = 15;

    localparam int DIM_W    = 15;
    localparam int FMT_W    = 3;
    localparam int LEVEL_W  = 4;
    localparam int LAYER_W  = 12;
    localparam int ROW_W    = 17;
    localparam int AREA_W   = 2 * DIM_W;
    localparam int SUB_W    = 31;
    localparam int SUM_W    = 33;
    localparam int OFS_W    = 43;
    localparam int OFS_MUL_W = SUM_W + LAYER_W;
    localparam int OFS_SUM_W = OFS_MUL_W + 1;
    localparam int STAT_W   = 3;
    localparam int SHIFT_W  = 5;

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 15;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_BITS    = 2 * DIM_W + ROW_W + SUB_W + 2 * OFS_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_AW-1:0] {
        REG_BASE_WIDTH    = 3'd0,
        REG_BASE_HEIGHT   = 3'd1,
        REG_PIXEL_FORMAT  = 3'd2,
        REG_LEVEL_COUNT   = 3'd3,
        REG_LAYER_COUNT   = 3'd4,
        REG_IS_ARRAY_VIEW = 3'd5
    } tsl_reg_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGBA8_UNORM = 3'd0,
        FMT_R32_FLOAT   = 3'd1,
        FMT_D32_FLOAT   = 3'd2,
        FMT_R16_UINT    = 3'd3,
        FMT_R32_UINT    = 3'd4
    } tsl_fmt_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_ZERO_EXTENT = 3'd1,
        STAT_NO_LAYERS   = 3'd2,
        STAT_NO_LEVELS   = 3'd3,
        STAT_2D_LAYERS   = 3'd4,
        STAT_CHAIN_LONG  = 3'd5
    } tsl_status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SUM,
        SEQ_TOTAL
    } tsl_seq_t;

    typedef struct packed {
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [FMT_W-1:0]   pixel_format;
        logic [LEVEL_W-1:0] level_count;
        logic [LAYER_W-1:0] layer_count;
        logic               is_array_view;
    } tsl_cfg_t;

    typedef struct packed {
        logic               busy;
        logic [SUM_W-1:0]   layer_size;
        logic [OFS_W-1:0]   total_bytes;
        tsl_status_t        view_status;
    } tsl_layout_t;

    // Level extent: base shifted down, never below one texel.
    function automatic logic [DIM_W-1:0] dim_at(logic [DIM_W-1:0] base,
                                                logic [SHIFT_W-1:0] lvl);
        logic [DIM_W-1:0] v;
        v = base >> lvl;
        return (v == '0) ? DIM_W'(1) : v;
    endfunction

    // Multiply by bytes per texel; unknown formats give zero.
    function automatic logic [SUM_W-1:0] texel_scale(logic [SUM_W-1:0] x,
                                                     logic [FMT_W-1:0] fmt);
        logic [SUM_W-1:0] r;
        r = '0;
        unique case (fmt)
            FMT_RGBA8_UNORM, FMT_R32_FLOAT, FMT_D32_FLOAT, FMT_R32_UINT: r = x << 2;
            FMT_R16_UINT: r = x << 1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[design/tsl_level_table.sv]
module tsl_level_table #(
    parameter int MAX_LEVELS = tsl_pkg::MAX_LEVELS_DEF,
    parameter int TAB_AW     = $clog2(MAX_LEVELS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsl_pkg::tsl_cfg_t           cfg,
    input  logic                        restart,
    input  logic [TAB_AW-1:0]           rd_addr,
    output logic [tsl_pkg::SUM_W-1:0]   rd_data,
    output tsl_pkg::tsl_layout_t        layout
);

    localparam int TAB_N = MAX_LEVELS + 1;

    tsl_pkg::tsl_seq_t                state_reg, state_next;
    logic [TAB_AW-1:0]                idx_reg, idx_next;
    logic [tsl_pkg::SUM_W-1:0]        acc_reg, acc_next;

    logic [tsl_pkg::SUM_W-1:0]        ptab_reg [TAB_N];
    logic [tsl_pkg::SUM_W-1:0]        layer_size_reg;
    logic [tsl_pkg::OFS_W-1:0]        total_reg;
    tsl_pkg::tsl_status_t             status_reg, status_next;

    logic [tsl_pkg::DIM_W-1:0]        w_lvl, h_lvl;
    logic [tsl_pkg::AREA_W-1:0]       area;
    logic [tsl_pkg::SUM_W-1:0]        lsize;
    logic [TAB_AW-1:0]                nsum;
    logic [tsl_pkg::OFS_MUL_W-1:0]    total_prod;
    logic [tsl_pkg::DIM_W-1:0]        big;
    logic [tsl_pkg::LEVEL_W-1:0]      msb;
    logic [tsl_pkg::LEVEL_W-1:0]      deepest;

    assign rd_data = ptab_reg[rd_addr];

    assign layout.busy        = (state_reg != tsl_pkg::SEQ_IDLE);
    assign layout.layer_size  = layer_size_reg;
    assign layout.total_bytes = total_reg;
    assign layout.view_status = status_reg;

    assign nsum = (int'(cfg.level_count) > MAX_LEVELS) ? TAB_AW'(MAX_LEVELS)
                                                       : TAB_AW'(cfg.level_count);

    // One level per cycle: extent, area, bytes.
    assign w_lvl = tsl_pkg::dim_at(cfg.base_width, tsl_pkg::SHIFT_W'(idx_reg));
    assign h_lvl = tsl_pkg::dim_at(cfg.base_height, tsl_pkg::SHIFT_W'(idx_reg));
    assign area  = w_lvl * h_lvl;
    assign lsize = tsl_pkg::texel_scale(tsl_pkg::SUM_W'(area), cfg.pixel_format);

    assign total_prod = layer_size_reg * cfg.layer_count;
    assign big = (cfg.base_width > cfg.base_height) ? cfg.base_width : cfg.base_height;

    always_comb
    begin
        msb = '0;
        for (int b = 0; b < tsl_pkg::DIM_W; b++)
        begin
            if (big[b])
            begin
                msb = tsl_pkg::LEVEL_W'(b);
            end
        end
        deepest = (big > tsl_pkg::DIM_W'(1)) ? msb + tsl_pkg::LEVEL_W'(1)
                                             : tsl_pkg::LEVEL_W'(1);
    end

    always_comb
    begin
        priority if (cfg.base_width == '0 || cfg.base_height == '0)
            status_next = tsl_pkg::STAT_ZERO_EXTENT;
        else if (cfg.layer_count == '0)
            status_next = tsl_pkg::STAT_NO_LAYERS;
        else if (cfg.level_count == '0)
            status_next = tsl_pkg::STAT_NO_LEVELS;
        else if (!cfg.is_array_view && cfg.layer_count != tsl_pkg::LAYER_W'(1))
            status_next = tsl_pkg::STAT_2D_LAYERS;
        else if (cfg.level_count > deepest)
            status_next = tsl_pkg::STAT_CHAIN_LONG;
        else
            status_next = tsl_pkg::STAT_OK;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            tsl_pkg::SEQ_SUM:
            begin
                acc_next = acc_reg + lsize;
                if (idx_reg == TAB_AW'(MAX_LEVELS))
                begin
                    state_next = tsl_pkg::SEQ_TOTAL;
                end
                else
                begin
                    idx_next = idx_reg + TAB_AW'(1);
                end
            end
            tsl_pkg::SEQ_TOTAL:
            begin
                state_next = tsl_pkg::SEQ_IDLE;
            end
            tsl_pkg::SEQ_IDLE:
            begin
                state_next = tsl_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = tsl_pkg::SEQ_IDLE;
            end
        endcase
        // Any register write rebuilds the table from level zero.
        if (restart)
        begin
            state_next = tsl_pkg::SEQ_SUM;
            idx_next   = '0;
            acc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsl_pkg::SEQ_SUM;
            idx_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tsl_pkg::SEQ_SUM)
        begin
            // Entry i holds the bytes of all levels below i.
            ptab_reg[idx_reg] <= acc_reg;
            if (idx_reg == nsum)
            begin
                layer_size_reg <= acc_reg;
            end
        end
        if (state_reg == tsl_pkg::SEQ_TOTAL)
        begin
            total_reg  <= (|total_prod[tsl_pkg::OFS_MUL_W-1:tsl_pkg::OFS_W])
                          ? '1 : total_prod[tsl_pkg::OFS_W-1:0];
            status_reg <= status_next;
        end
    end

endmodule

[design/texture_subresource_layout.sv]
// Channel   Dir  Handshake              Content
// s_axis    in   tvalid/tready          tdata: level, layer
// m_axis    out  tvalid/tready          tdata: level sizes, offset, total, status
// cfg       in   cfg_valid/cfg_ready    cfg_addr register index, cfg_data value
//
// One query per cycle while s_axis_tready is high; each result passes through the stage
// registers in order. After reset and after every register write a level sequencer
// walks MAX_LEVELS + 1 table entries and one total step, with s_axis_tready held low.
// Stalls on m_axis back up through the four stage registers without loss.
module texture_subresource_layout #(
    parameter int MAX_LEVELS = tsl_pkg::MAX_LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] level, [15:4] layer
    input  logic [tsl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [14:0] level_width, [29:15] level_height, [46:30] row_bytes,
    // [77:47] sub_size, [120:78] byte_offset, [163:121] total_bytes,
    // [166:164] view_status, [167] zero
    output logic [tsl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsl_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [tsl_pkg::CFG_DW-1:0]        cfg_data
);

    localparam int TAB_AW = $clog2(MAX_LEVELS + 1);

    tsl_pkg::tsl_cfg_t              cfg_reg;
    tsl_pkg::tsl_layout_t           layout;
    logic                           cfg_write;

    logic [tsl_pkg::LEVEL_W-1:0]    in_level;
    logic [tsl_pkg::LAYER_W-1:0]    in_layer;
    logic [TAB_AW-1:0]              rd_addr;
    logic [tsl_pkg::SUM_W-1:0]      rd_data;

    logic                           v1_reg, v2_reg, v3_reg, v4_reg;
    logic                           rdy1, rdy2, rdy3, rdy4;
    logic                           take;

    logic [tsl_pkg::DIM_W-1:0]      lw_next, lh_next;
    logic [tsl_pkg::ROW_W-1:0]      row_next;

    logic [tsl_pkg::DIM_W-1:0]      lw1_reg, lh1_reg, lw2_reg, lh2_reg;
    logic [tsl_pkg::DIM_W-1:0]      lw3_reg, lh3_reg, lw4_reg, lh4_reg;
    logic [tsl_pkg::ROW_W-1:0]      row1_reg, row2_reg, row3_reg, row4_reg;
    logic [tsl_pkg::SUM_W-1:0]      pre1_reg, pre2_reg;
    logic [tsl_pkg::LAYER_W-1:0]    layer1_reg;
    logic [tsl_pkg::AREA_W+1:0]     sub2_reg;
    logic [tsl_pkg::OFS_MUL_W-1:0]  mul2_reg;
    logic [tsl_pkg::SUB_W-1:0]      sub3_reg, sub4_reg;
    logic [tsl_pkg::OFS_SUM_W-1:0]  ofs3_reg;
    logic [tsl_pkg::OFS_W-1:0]      ofs4_reg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_width    <= tsl_pkg::DIM_W'(1);
            cfg_reg.base_height   <= tsl_pkg::DIM_W'(1);
            cfg_reg.pixel_format  <= tsl_pkg::FMT_RGBA8_UNORM;
            cfg_reg.level_count   <= tsl_pkg::LEVEL_W'(1);
            cfg_reg.layer_count   <= tsl_pkg::LAYER_W'(1);
            cfg_reg.is_array_view <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                tsl_pkg::REG_BASE_WIDTH:
                    cfg_reg.base_width <= cfg_data[tsl_pkg::DIM_W-1:0];
                tsl_pkg::REG_BASE_HEIGHT:
                    cfg_reg.base_height <= cfg_data[tsl_pkg::DIM_W-1:0];
                tsl_pkg::REG_PIXEL_FORMAT:
                    cfg_reg.pixel_format <= cfg_data[tsl_pkg::FMT_W-1:0];
                tsl_pkg::REG_LEVEL_COUNT:
                    cfg_reg.level_count <= cfg_data[tsl_pkg::LEVEL_W-1:0];
                tsl_pkg::REG_LAYER_COUNT:
                    cfg_reg.layer_count <= cfg_data[tsl_pkg::LAYER_W-1:0];
                tsl_pkg::REG_IS_ARRAY_VIEW:
                    cfg_reg.is_array_view <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tsl_level_table #(
        .MAX_LEVELS (MAX_LEVELS),
        .TAB_AW     (TAB_AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .restart (cfg_write),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .layout  (layout)
    );

    // Stall chain: a stage advances when it is empty or its successor moves.
    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_axis_tready = rdy1 && !layout.busy && !cfg_valid;
    assign take          = s_axis_tvalid && s_axis_tready;

    assign in_level = s_axis_tdata[tsl_pkg::LEVEL_W-1:0];
    assign in_layer = s_axis_tdata[tsl_pkg::LEVEL_W +: tsl_pkg::LAYER_W];

    assign rd_addr = (int'(in_level) > MAX_LEVELS) ? TAB_AW'(MAX_LEVELS)
                                                   : TAB_AW'(in_level);

    assign lw_next  = tsl_pkg::dim_at(cfg_reg.base_width, tsl_pkg::SHIFT_W'(in_level));
    assign lh_next  = tsl_pkg::dim_at(cfg_reg.base_height, tsl_pkg::SHIFT_W'(in_level));
    assign row_next = tsl_pkg::ROW_W'(tsl_pkg::texel_scale(tsl_pkg::SUM_W'(lw_next),
                                                           cfg_reg.pixel_format));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= take;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: level extents, row bytes, prefix lookup.
        if (rdy1)
        begin
            lw1_reg    <= lw_next;
            lh1_reg    <= lh_next;
            row1_reg   <= row_next;
            pre1_reg   <= rd_data;
            layer1_reg <= in_layer;
        end
        // Stage 2: level size and layer offset products.
        if (rdy2)
        begin
            lw2_reg  <= lw1_reg;
            lh2_reg  <= lh1_reg;
            row2_reg <= row1_reg;
            pre2_reg <= pre1_reg;
            sub2_reg <= row1_reg * lh1_reg;
            mul2_reg <= layout.layer_size * layer1_reg;
        end
        // Stage 3: add lower levels, clamp size.
        if (rdy3)
        begin
            lw3_reg  <= lw2_reg;
            lh3_reg  <= lh2_reg;
            row3_reg <= row2_reg;
            sub3_reg <= (|sub2_reg[tsl_pkg::AREA_W+1:tsl_pkg::SUB_W])
                        ? '1 : sub2_reg[tsl_pkg::SUB_W-1:0];
            ofs3_reg <= tsl_pkg::OFS_SUM_W'(mul2_reg) + tsl_pkg::OFS_SUM_W'(pre2_reg);
        end
        // Stage 4: clamp offset into the output register.
        if (rdy4)
        begin
            lw4_reg  <= lw3_reg;
            lh4_reg  <= lh3_reg;
            row4_reg <= row3_reg;
            sub4_reg <= sub3_reg;
            ofs4_reg <= (|ofs3_reg[tsl_pkg::OFS_SUM_W-1:tsl_pkg::OFS_W])
                        ? '1 : ofs3_reg[tsl_pkg::OFS_W-1:0];
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = tsl_pkg::OUT_TDATA_W'({layout.view_status, layout.total_bytes,
                                                 ofs4_reg, sub4_reg, row4_reg,
                                                 lh4_reg, lw4_reg});

endmodule

[sim/texture_subresource_layout_test.sv]
`default_nettype none

module texture_subresource_layout_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_W       = tsl_pkg::DIM_W;
    localparam int FMT_W       = tsl_pkg::FMT_W;
    localparam int LEVEL_W     = tsl_pkg::LEVEL_W;
    localparam int LAYER_W     = tsl_pkg::LAYER_W;
    localparam int ROW_W       = tsl_pkg::ROW_W;
    localparam int SUB_W       = tsl_pkg::SUB_W;
    localparam int OFS_W       = tsl_pkg::OFS_W;
    localparam int STAT_W      = tsl_pkg::STAT_W;
    localparam int CFG_AW      = tsl_pkg::CFG_AW;
    localparam int CFG_DW      = tsl_pkg::CFG_DW;
    localparam int IN_TDATA_W  = tsl_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = tsl_pkg::OUT_TDATA_W;

    localparam int LEVEL_LIMIT    = tsl_pkg::MAX_LEVELS_DEF;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_QUERIES = 1200;
    localparam int CALM_TAIL      = 150;
    localparam int REPORT_LIMIT   = 10;

    // Bit positions of the result fields in m_axis_tdata
    localparam int LW_LO  = 0;
    localparam int LH_LO  = LW_LO + DIM_W;
    localparam int ROW_LO = LH_LO + DIM_W;
    localparam int SUB_LO = ROW_LO + ROW_W;
    localparam int OFS_LO = SUB_LO + SUB_W;
    localparam int TOT_LO = OFS_LO + OFS_W;
    localparam int ST_LO  = TOT_LO + OFS_W;

    typedef struct packed {
        logic [DIM_W-1:0]     level_width;
        logic [DIM_W-1:0]     level_height;
        logic [ROW_W-1:0]     row_bytes;
        logic [SUB_W-1:0]     sub_size;
        logic [OFS_W-1:0]     byte_offset;
        logic [OFS_W-1:0]     total_bytes;
        tsl_pkg::tsl_status_t view_status;
    } layout_t;

    typedef enum logic [1:0] {
        OP_QUERY,
        OP_WRITE,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t           kind;
        logic [LEVEL_W-1:0] mip;
        logic [LAYER_W-1:0] layer;
        tsl_pkg::tsl_reg_t  addr;
        logic [CFG_DW-1:0]  data;
        bit                 idle_ok;
    } plan_op_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_AW-1:0]      cfg_addr = '0;
    logic [CFG_DW-1:0]      cfg_data = '0;

    texture_subresource_layout dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // Predictor copy of the registers
    logic [DIM_W-1:0]   cur_width;
    logic [DIM_W-1:0]   cur_height;
    logic [FMT_W-1:0]   cur_format;
    logic [LEVEL_W-1:0] cur_levels;
    logic [LAYER_W-1:0] cur_layers;
    logic               cur_array;

    plan_op_t pending_ops [$];
    layout_t  expected_layouts [$];

    string field_names [7] = '{"level_width", "level_height", "row_bytes", "sub_size",
                               "byte_offset", "total_bytes", "view_status"};

    int  queries_sent;
    int  results_done;
    int  fail_count;
    int  reported;
    int  cycle_count;
    int  send_gap;
    int  ready_hold;
    bit  pace_idle;
    bit  query_up;
    bit  write_up;

    // Stimulus planning state
    int  random_planned;
    bit  seg_idle;
    int  plan_width;
    int  plan_height;
    int  plan_levels;
    int  plan_layers;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] texel_bytes(logic [FMT_W-1:0] fmt);
        case (fmt)
            tsl_pkg::FMT_RGBA8_UNORM, tsl_pkg::FMT_R32_FLOAT,
            tsl_pkg::FMT_D32_FLOAT, tsl_pkg::FMT_R32_UINT: return 64'd4;
            tsl_pkg::FMT_R16_UINT: return 64'd2;
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] shrink(logic [63:0] base, int lvl);
        logic [63:0] v;
        v = base >> lvl;
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic logic [63:0] clip(logic [63:0] v, int bits);
        logic [63:0] top;
        top = (64'd1 << bits) - 1;
        return (v > top) ? top : v;
    endfunction

    function automatic int chain_depth(int w, int h);
        int big;
        int depth;
        big = (w > h) ? w : h;
        depth = 1;
        while (big > 1)
        begin
            big = big >> 1;
            depth++;
        end
        return depth;
    endfunction

    function automatic layout_t compute_layout(logic [LEVEL_W-1:0] mip,
                                               logic [LAYER_W-1:0] layer);
        layout_t     r;
        logic [63:0] bpt;
        logic [63:0] lw;
        logic [63:0] lh;
        logic [63:0] row;
        logic [63:0] layer_sum;
        logic [63:0] below;
        logic [63:0] sz;
        int          n_sum;
        int          n_pre;
        bpt = texel_bytes(cur_format);
        lw = shrink(64'(cur_width), int'(mip));
        lh = shrink(64'(cur_height), int'(mip));
        row = lw * bpt;
        n_sum = (int'(cur_levels) < LEVEL_LIMIT) ? int'(cur_levels) : LEVEL_LIMIT;
        n_pre = (int'(mip) < LEVEL_LIMIT) ? int'(mip) : LEVEL_LIMIT;
        layer_sum = 0;
        below = 0;
        for (int l = 0; l < LEVEL_LIMIT; l++)
        begin
            sz = shrink(64'(cur_width), l) * bpt * shrink(64'(cur_height), l);
            if (l < n_sum)
                layer_sum += sz;
            if (l < n_pre)
                below += sz;
        end

        // first failing check wins
        if (cur_width == 0 || cur_height == 0)
            r.view_status = tsl_pkg::STAT_ZERO_EXTENT;
        else if (cur_layers == 0)
            r.view_status = tsl_pkg::STAT_NO_LAYERS;
        else if (cur_levels == 0)
            r.view_status = tsl_pkg::STAT_NO_LEVELS;
        else if (!cur_array && cur_layers != 1)
            r.view_status = tsl_pkg::STAT_2D_LAYERS;
        else if (int'(cur_levels) > chain_depth(int'(cur_width), int'(cur_height)))
            r.view_status = tsl_pkg::STAT_CHAIN_LONG;
        else
            r.view_status = tsl_pkg::STAT_OK;

        r.level_width  = lw[DIM_W-1:0];
        r.level_height = lh[DIM_W-1:0];
        r.row_bytes    = ROW_W'(clip(row, ROW_W));
        r.sub_size     = SUB_W'(clip(row * lh, SUB_W));
        r.byte_offset  = OFS_W'(clip(layer_sum * 64'(layer) + below, OFS_W));
        r.total_bytes  = OFS_W'(clip(layer_sum * 64'(cur_layers), OFS_W));
        return r;
    endfunction

    function automatic logic [CFG_DW-1:0] reg_mask(tsl_pkg::tsl_reg_t addr);
        case (addr)
            tsl_pkg::REG_BASE_WIDTH, tsl_pkg::REG_BASE_HEIGHT:
                return CFG_DW'((1 << DIM_W) - 1);
            tsl_pkg::REG_PIXEL_FORMAT: return CFG_DW'((1 << FMT_W) - 1);
            tsl_pkg::REG_LEVEL_COUNT: return CFG_DW'((1 << LEVEL_W) - 1);
            tsl_pkg::REG_LAYER_COUNT: return CFG_DW'((1 << LAYER_W) - 1);
            default: return CFG_DW'(1);
        endcase
    endfunction

    task automatic apply_write(tsl_pkg::tsl_reg_t addr, logic [CFG_DW-1:0] data);
        case (addr)
            tsl_pkg::REG_BASE_WIDTH: cur_width = data[DIM_W-1:0];
            tsl_pkg::REG_BASE_HEIGHT: cur_height = data[DIM_W-1:0];
            tsl_pkg::REG_PIXEL_FORMAT: cur_format = data[FMT_W-1:0];
            tsl_pkg::REG_LEVEL_COUNT: cur_levels = data[LEVEL_W-1:0];
            tsl_pkg::REG_LAYER_COUNT: cur_layers = data[LAYER_W-1:0];
            tsl_pkg::REG_IS_ARRAY_VIEW: cur_array = data[0];
            default: ;
        endcase
    endtask

    task automatic check_result();
        layout_t     want;
        logic [63:0] want_f [7];
        logic [63:0] got_f [7];
        bit          bad;
        results_done++;
        if (expected_layouts.size() == 0)
        begin
            fail_count++;
            if (reported < REPORT_LIMIT)
                $display("result beat with no query outstanding: %h", m_axis_tdata);
            reported++;
            return;
        end
        want = expected_layouts.pop_front();
        want_f = '{64'(want.level_width), 64'(want.level_height), 64'(want.row_bytes),
                   64'(want.sub_size), 64'(want.byte_offset), 64'(want.total_bytes),
                   64'(want.view_status)};
        got_f = '{64'(m_axis_tdata[LW_LO +: DIM_W]), 64'(m_axis_tdata[LH_LO +: DIM_W]),
                  64'(m_axis_tdata[ROW_LO +: ROW_W]), 64'(m_axis_tdata[SUB_LO +: SUB_W]),
                  64'(m_axis_tdata[OFS_LO +: OFS_W]), 64'(m_axis_tdata[TOT_LO +: OFS_W]),
                  64'(m_axis_tdata[ST_LO +: STAT_W])};
        bad = 1'b0;
        for (int i = 0; i < 7; i++)
        begin
            if (want_f[i] !== got_f[i])
            begin
                bad = 1'b1;
                if (reported < REPORT_LIMIT)
                    $display("result %0d %s: expected %0d, got %0d",
                             results_done, field_names[i], want_f[i], got_f[i]);
            end
        end
        if (bad)
        begin
            fail_count++;
            reported++;
        end
    endtask

    // Monitor: check results, track register writes, predict accepted queries
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_width = DIM_W'(1);
            cur_height = DIM_W'(1);
            cur_format = tsl_pkg::FMT_RGBA8_UNORM;
            cur_levels = LEVEL_W'(1);
            cur_layers = LAYER_W'(1);
            cur_array = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                apply_write(tsl_pkg::tsl_reg_t'(cfg_addr), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                expected_layouts.insert(expected_layouts.size(),
                                        compute_layout(s_axis_tdata[LEVEL_W-1:0],
                                                       s_axis_tdata[LEVEL_W +: LAYER_W]));
        end
    end

    // Driver: query beats and register writes, one at a time from the plan
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            cfg_valid <= 1'b0;
            cfg_addr <= tsl_pkg::REG_BASE_WIDTH;
            cfg_data <= '0;
            query_up = 1'b0;
            write_up = 1'b0;
            send_gap = 0;
            queries_sent = 0;
        end
        else
        begin
            query_up = s_axis_tvalid;
            write_up = cfg_valid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                query_up = 1'b0;
                queries_sent++;
            end
            if (cfg_valid && cfg_ready)
                write_up = 1'b0;
            if (!query_up && !write_up)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_ops.size() > 0)
                begin
                    pace_idle = pending_ops[0].idle_ok;
                    case (pending_ops[0].kind)
                        OP_QUERY:
                        begin
                            s_axis_tdata <= {pending_ops[0].layer, pending_ops[0].mip};
                            query_up = 1'b1;
                            if (pending_ops[0].idle_ok && $urandom_range(0, 5) == 0)
                                send_gap = $urandom_range(1, 12);
                            void'(pending_ops.pop_front());
                        end
                        OP_WRITE:
                        begin
                            // registers change only with nothing in flight
                            if (queries_sent == results_done)
                            begin
                                cfg_addr <= pending_ops[0].addr;
                                cfg_data <= pending_ops[0].data;
                                write_up = 1'b1;
                                void'(pending_ops.pop_front());
                            end
                        end
                        default:
                        begin
                            if (queries_sent == results_done)
                                void'(pending_ops.pop_front());
                        end
                    endcase
                end
            end
            s_axis_tvalid <= query_up;
            cfg_valid <= write_up;
        end
    end

    // Result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (ready_hold > 0)
                ready_hold--;
            else if (pace_idle && $urandom_range(0, 11) == 0)
                ready_hold = $urandom_range(1, 12);
            m_axis_tready <= (ready_hold == 0);
        end
    end

    task automatic add_query(int mip, int layer);
        plan_op_t op;
        op.kind = OP_QUERY;
        op.mip = LEVEL_W'(mip);
        op.layer = LAYER_W'(layer);
        op.addr = tsl_pkg::REG_BASE_WIDTH;
        op.data = '0;
        op.idle_ok = seg_idle && (random_planned < RANDOM_QUERIES - CALM_TAIL);
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_write(tsl_pkg::tsl_reg_t addr, int value, bit garble);
        plan_op_t          op;
        logic [CFG_DW-1:0] mask;
        mask = reg_mask(addr);
        op.kind = OP_WRITE;
        op.mip = '0;
        op.layer = '0;
        op.addr = addr;
        op.data = CFG_DW'(value) & mask;
        // junk above the register width must be dropped by the block
        if (garble)
            op.data = op.data | (CFG_DW'($urandom_range(0, 32767)) & ~mask);
        op.idle_ok = seg_idle && (random_planned < RANDOM_QUERIES - CALM_TAIL);
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic add_setup(int w, int h, int fmt, int levels, int layers, int arr);
        add_write(tsl_pkg::REG_BASE_WIDTH, w, 1'b0);
        add_write(tsl_pkg::REG_BASE_HEIGHT, h, 1'b0);
        add_write(tsl_pkg::REG_PIXEL_FORMAT, fmt, 1'b0);
        add_write(tsl_pkg::REG_LEVEL_COUNT, levels, 1'b0);
        add_write(tsl_pkg::REG_LAYER_COUNT, layers, 1'b0);
        add_write(tsl_pkg::REG_IS_ARRAY_VIEW, arr, 1'b0);
    endtask

    function automatic int pick_extent();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(0, 32767);
        if (r == 2)
            return 16384;
        return $urandom_range(1, 1 << $urandom_range(0, 14));
    endfunction

    task automatic plan_random_segment(bit drain_first);
        int       fmt;
        int       arr;
        int       deepest;
        int       n;
        plan_op_t drain_op;
        plan_width = pick_extent();
        plan_height = pick_extent();
        deepest = chain_depth(plan_width, plan_height);
        if (deepest > LEVEL_LIMIT)
            deepest = LEVEL_LIMIT;
        fmt = ($urandom_range(0, 9) < 9)
              ? $urandom_range(tsl_pkg::FMT_RGBA8_UNORM, tsl_pkg::FMT_R32_UINT)
              : $urandom_range(5, 7);
        plan_levels = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(1, deepest);
        case ($urandom_range(0, 3))
            0: plan_layers = $urandom_range(0, 4095);
            1: plan_layers = 1;
            default: plan_layers = $urandom_range(1, 2048);
        endcase
        arr = (plan_layers != 1 && $urandom_range(0, 4) != 0) ? 1 : $urandom_range(0, 1);
        seg_idle = ($urandom_range(0, 3) != 0);
        if (drain_first)
        begin
            drain_op.kind = OP_DRAIN;
            drain_op.mip = '0;
            drain_op.layer = '0;
            drain_op.addr = tsl_pkg::REG_BASE_WIDTH;
            drain_op.data = '0;
            drain_op.idle_ok = 1'b0;
            pending_ops.insert(pending_ops.size(), drain_op);
        end
        add_write(tsl_pkg::REG_BASE_WIDTH, plan_width, 1'b1);
        add_write(tsl_pkg::REG_BASE_HEIGHT, plan_height, 1'b1);
        add_write(tsl_pkg::REG_PIXEL_FORMAT, fmt, 1'b1);
        add_write(tsl_pkg::REG_LEVEL_COUNT, plan_levels, 1'b1);
        add_write(tsl_pkg::REG_LAYER_COUNT, plan_layers, 1'b1);
        add_write(tsl_pkg::REG_IS_ARRAY_VIEW, arr, 1'b1);
        n = $urandom_range(10, 60);
        for (int i = 0; i < n && random_planned < RANDOM_QUERIES; i++)
        begin
            add_query(($urandom_range(0, 3) != 0 && plan_levels > 0)
                          ? $urandom_range(0, plan_levels - 1) : $urandom_range(0, 15),
                      ($urandom_range(0, 3) != 0 && plan_layers > 0)
                          ? $urandom_range(0, plan_layers - 1) : $urandom_range(0, 4095));
            random_planned++;
        end
    endtask

    initial
    begin
        bit drained;
        fail_count = 0;
        reported = 0;
        results_done = 0;
        random_planned = 0;
        pace_idle = 1'b1;
        seg_idle = 1'b1;

        // reset configuration
        add_query(0, 0);
        add_query(15, 4095);
        // largest legal texture, full chain
        add_setup(16384, 16384, tsl_pkg::FMT_R32_UINT, 15, 2048, 1);
        add_query(0, 0);
        add_query(14, 2047);
        add_query(15, 2048);
        add_query(7, 4095);
        // zero extent still yields one texel
        add_setup(0, 5, tsl_pkg::FMT_RGBA8_UNORM, 3, 1, 0);
        add_query(0, 0);
        add_query(2, 0);
        add_setup(8, 8, tsl_pkg::FMT_R16_UINT, 3, 0, 1);
        add_query(1, 1);
        add_setup(8, 8, tsl_pkg::FMT_R32_FLOAT, 0, 4, 1);
        add_query(0, 3);
        add_setup(8, 8, tsl_pkg::FMT_D32_FLOAT, 2, 4, 0);
        add_query(1, 2);
        // five levels on an 8x8 base is one too many
        add_setup(8, 8, tsl_pkg::FMT_RGBA8_UNORM, 5, 1, 0);
        add_query(4, 0);
        // unknown formats give zero bytes
        add_setup(100, 60, 5, 4, 3, 1);
        add_query(2, 1);
        add_write(tsl_pkg::REG_PIXEL_FORMAT, 6, 1'b0);
        add_query(3, 2);
        add_write(tsl_pkg::REG_PIXEL_FORMAT, 7, 1'b0);
        add_query(0, 5);
        // oversized base: sizes saturate
        add_setup(32767, 32767, tsl_pkg::FMT_R32_UINT, 15, 4095, 1);
        add_query(15, 4095);
        add_query(0, 4095);
        add_query(3, 1);

        drained = 1'b0;
        while (random_planned < RANDOM_QUERIES)
        begin
            plan_random_segment(!drained && random_planned > RANDOM_QUERIES / 2);
            if (random_planned > RANDOM_QUERIES / 2)
                drained = 1'b1;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || queries_sent != results_done ||
               s_axis_tvalid || cfg_valid)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (expected_layouts.size() != 0)
        begin
            fail_count++;
            $display("%0d expected results never arrived", expected_layouts.size());
        end
        if (fail_count == 0)
            $display("texture_subresource_layout test passed");
        else
            $display("texture_subresource_layout test failed");
        $finish;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("texture_subresource_layout test failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/tsl_pkg.sv
design/tsl_level_table.sv
design/texture_subresource_layout.sv
sim/texture_subresource_layout_test.sv
